FILE: rtl/assert_macros.svh
// Assertion macros shared by the sprite frame sequencer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

FILE: rtl/sfs_pkg.sv
// Shared types and codes for the sprite frame sequencer.
// No dependencies; imported by sfs_step, sprite_frame_sequencer and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package sfs_pkg;

	// Command codes carried in the mode field.
	localparam logic [2:0] MODE_TICK    = 3'd0;
	localparam logic [2:0] MODE_WRITE   = 3'd1;
	localparam logic [2:0] MODE_RESTART = 3'd2;
	localparam logic [2:0] MODE_PLAY    = 3'd3;
	localparam logic [2:0] MODE_PAUSE   = 3'd4;
	localparam logic [2:0] MODE_TOGGLE  = 3'd5;
	localparam logic [2:0] MODE_JUMP    = 3'd6;

	// Playback directions; the unused code plays forward.
	localparam logic [1:0] DIR_FORWARD  = 2'd0;
	localparam logic [1:0] DIR_REVERSE  = 2'd1;
	localparam logic [1:0] DIR_PINGPONG = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_TAG_LENGTH   = 2'd0;
	localparam logic [1:0] REG_TAG_DIRECTION = 2'd1;
	localparam logic [1:0] REG_REPEAT_COUNT = 2'd2;

	localparam int TAG_LENGTH_W = 9;
	localparam int DUR_W        = 16;

	// Control outcome of one frame step.
	typedef struct packed {
		logic       fwd;
		logic [7:0] repeats;
		logic       pause;
	} step_ctl_t;

	// One result item.
	typedef struct packed {
		logic [7:0] frame;
		logic       paused;
		logic       advanced;
		logic       err;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/sfs_step.sv
// Single frame step: advance, wrap or bounce, repeat countdown and clamp.
// Depends on sfs_pkg for step_ctl_t and the direction codes.
`timescale 1ns / 1ps
`default_nettype none

module sfs_step #(
	parameter int MAX_FRAMES = 256,
	localparam int AW = $clog2(MAX_FRAMES),
	localparam int LW = (AW + 1 > 9) ? AW + 1 : 9,
	localparam int SW = LW + 2
) (
	input  wire logic signed [SW-1:0] from,
	input  wire logic                 fwd,
	input  wire logic [LW-1:0]        len,
	input  wire logic [7:0]           repeats,
	input  wire logic [1:0]           direction,
	output logic [AW-1:0]             pos,
	output sfs_pkg::step_ctl_t        ctl
);
	import sfs_pkg::*;

	localparam logic signed [SW-1:0] S_ZERO = '0;
	localparam logic signed [SW-1:0] S_ONE  = SW'(1);
	localparam logic signed [SW-1:0] S_TWO  = SW'(2);

	logic signed [SW-1:0] lens;
	logic signed [SW-1:0] last;
	logic signed [SW-1:0] idx;
	logic                 leaves;

	always_comb begin
		lens = signed'({2'b00, len});
		last = lens - S_ONE;
		idx  = fwd ? from + S_ONE : from - S_ONE;
		leaves = fwd ? (idx >= lens) : (idx < S_ZERO);
		ctl.fwd = fwd;
		ctl.repeats = repeats;
		ctl.pause = 1'b0;
		if (leaves) begin
			if (repeats != 8'd1) begin
				if (direction == DIR_PINGPONG) begin
					ctl.fwd = !fwd;
					idx = fwd ? idx - S_TWO : idx + S_TWO;
				end else begin
					idx = fwd ? S_ZERO : last;
				end
				if (repeats > 8'd1) begin
					ctl.repeats = repeats - 8'd1;
				end
			end else begin
				// Last repeat: hold the end frame and stop.
				idx = fwd ? last : S_ZERO;
				ctl.pause = 1'b1;
			end
		end
		// A one-frame bounce or a shrunken tag can land outside the tag.
		if (idx < S_ZERO) begin
			idx = S_ZERO;
		end
		if (idx > last) begin
			idx = last;
		end
		pos = AW'(idx);
	end

endmodule

`default_nettype wire

FILE: rtl/sprite_frame_sequencer.sv
// Top level of the sprite frame sequencer: command handling, duration memory,
// configuration registers and result skid buffer. Depends on sfs_pkg, sfs_step
// and assert_macros.svh.
//
//   Channel   Signals                                   Direction
//   cmd       cmd_valid/cmd_ready, mode, elapsed_ms,    in
//             frame_number, duration_ms
//   res       res_valid/res_ready, current_frame,       out
//             is_paused, frame_advanced, range_error
//   cfg       psel, penable, pwrite, paddr, pwdata,     in/out
//             prdata, pready
//
// One command item is taken per cycle while cmd_ready is high; its result is registered
// in the output register, or in the skid entry if the result side stalls. The duration
// memory read for a frame load completes in the following cycle, and the timer takes the
// read data from there directly. A two-entry output (register plus skid) keeps commands
// flowing while the result side stalls; cmd_ready drops only when both entries hold results.
// Reset is asynchronous; the duration memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sprite_frame_sequencer #(
	parameter int MAX_FRAMES = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_ready,
	input  wire logic [2:0]  mode,
	input  wire logic [15:0] elapsed_ms,
	input  wire logic [7:0]  frame_number,
	input  wire logic [15:0] duration_ms,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic [7:0]       current_frame,
	output logic             is_paused,
	output logic             frame_advanced,
	output logic             range_error,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import sfs_pkg::*;

	localparam int AW = $clog2(MAX_FRAMES);
	localparam int LW = (AW + 1 > 9) ? AW + 1 : 9;
	localparam int SW = LW + 2;
	localparam logic signed [SW-1:0] S_ONE = SW'(1);

	// Configuration registers.
	logic [TAG_LENGTH_W-1:0] tag_length_q;
	logic [1:0]              tag_direction_q;
	logic [7:0]              repeat_count_q;

	// Playback state.
	logic [AW-1:0]    pos_q;
	logic [DUR_W-1:0] timer_q;
	logic             load_pend_q;
	logic             fwd_q;
	logic [7:0]       repeats_q;
	logic             paused_q;

	// Duration memory.
	logic [DUR_W-1:0] dur_mem [MAX_FRAMES];
	logic [DUR_W-1:0] rd_q;

	// Result register and skid.
	res_t res_q;
	res_t skid_q;
	logic skid_valid_q;

	logic             cmd_fire;
	logic             cfg_wr;
	logic [1:0]       cfg_idx;
	logic [LW-1:0]    len_eff;
	logic [DUR_W-1:0] timer_cur;
	logic signed [SW-1:0] step_from;
	logic             step_fwd;
	logic [7:0]       step_rep;
	logic [AW-1:0]    step_pos;
	step_ctl_t        step_ctl;

	logic             use_step;
	logic [AW-1:0]    pos_next;
	logic [DUR_W-1:0] timer_next;
	logic             load_next;
	logic             fwd_next;
	logic [7:0]       repeats_next;
	logic             paused_next;
	logic             err;
	logic             mem_we;
	logic [AW-1:0]    rd_addr;
	res_t             res_new;

	assign cmd_fire  = cmd_valid && cmd_ready;
	assign cmd_ready = !skid_valid_q;
	assign pready    = 1'b1;
	assign cfg_idx   = paddr[3:2];
	assign cfg_wr    = psel && penable && pwrite && pready;

	// The timer value after a frame load is the memory data read last cycle.
	assign timer_cur = load_pend_q ? rd_q : timer_q;

	always_comb begin
		len_eff = LW'(tag_length_q);
		if (len_eff == '0) begin
			len_eff = LW'(1);
		end
		if (len_eff > LW'(MAX_FRAMES)) begin
			len_eff = LW'(MAX_FRAMES);
		end
	end

	always_comb begin
		if (mode == MODE_RESTART) begin
			step_fwd  = (tag_direction_q != DIR_REVERSE);
			step_rep  = repeat_count_q;
			step_from = step_fwd ? -S_ONE : signed'({2'b00, len_eff});
		end else begin
			step_fwd  = fwd_q;
			step_rep  = repeats_q;
			step_from = signed'(SW'(pos_q));
		end
	end

	sfs_step #(
		.MAX_FRAMES(MAX_FRAMES)
	) u_step (
		.from      (step_from),
		.fwd       (step_fwd),
		.len       (len_eff),
		.repeats   (step_rep),
		.direction (tag_direction_q),
		.pos       (step_pos),
		.ctl       (step_ctl)
	);

	always_comb begin
		use_step     = 1'b0;
		pos_next     = pos_q;
		timer_next   = timer_cur;
		load_next    = 1'b0;
		fwd_next     = fwd_q;
		repeats_next = repeats_q;
		paused_next  = paused_q;
		err          = 1'b0;
		mem_we       = 1'b0;
		rd_addr      = step_pos;
		if (cmd_fire) begin
			unique case (mode)
				MODE_TICK: begin
					if (!paused_q) begin
						if (elapsed_ms >= timer_cur) begin
							use_step = 1'b1;
						end else begin
							timer_next = timer_cur - elapsed_ms;
						end
					end
				end
				MODE_WRITE: begin
					mem_we = (32'(frame_number) < 32'(MAX_FRAMES));
				end
				MODE_RESTART: begin
					use_step = 1'b1;
				end
				MODE_PLAY: begin
					paused_next = 1'b0;
				end
				MODE_PAUSE: begin
					paused_next = 1'b1;
				end
				MODE_TOGGLE: begin
					paused_next = !paused_q;
				end
				MODE_JUMP: begin
					if (LW'(frame_number) >= len_eff) begin
						err = 1'b1;
					end else begin
						pos_next  = AW'(frame_number);
						rd_addr   = AW'(frame_number);
						load_next = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (use_step) begin
				pos_next     = step_pos;
				load_next    = 1'b1;
				fwd_next     = step_ctl.fwd;
				repeats_next = step_ctl.repeats;
				paused_next  = paused_q || step_ctl.pause;
			end
		end
		res_new.frame    = 8'(pos_next);
		res_new.paused   = paused_next;
		res_new.advanced = (pos_next != pos_q);
		res_new.err      = err;
	end

	// Duration memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			dur_mem[AW'(frame_number)] <= duration_ms;
		end
	end

	always_ff @(posedge clk) begin
		if (load_next) begin
			rd_q <= dur_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			timer_q     <= '0;
			load_pend_q <= 1'b0;
			fwd_q       <= 1'b1;
			repeats_q   <= '0;
			paused_q    <= 1'b1;
		end else begin
			pos_q       <= pos_next;
			timer_q     <= timer_next;
			load_pend_q <= load_next;
			fwd_q       <= fwd_next;
			repeats_q   <= repeats_next;
			paused_q    <= paused_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_length_q    <= TAG_LENGTH_W'(1);
			tag_direction_q <= DIR_FORWARD;
			repeat_count_q  <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_TAG_LENGTH:    tag_length_q    <= pwdata[TAG_LENGTH_W-1:0];
				REG_TAG_DIRECTION: tag_direction_q <= pwdata[1:0];
				REG_REPEAT_COUNT:  repeat_count_q  <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_TAG_LENGTH:    prdata = 32'(tag_length_q);
			REG_TAG_DIRECTION: prdata = 32'(tag_direction_q);
			REG_REPEAT_COUNT:  prdata = 32'(repeat_count_q);
			default:           prdata = '0;
		endcase
	end

	// Output register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (res_ready || !res_valid) begin
			if (skid_valid_q) begin
				res_valid    <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				res_valid <= cmd_fire;
			end
		end else if (cmd_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready || !res_valid) begin
			res_q <= skid_valid_q ? skid_q : res_new;
		end else if (cmd_fire) begin
			skid_q <= res_new;
		end
	end

	assign current_frame  = res_q.frame;
	assign is_paused      = res_q.paused;
	assign frame_advanced = res_q.advanced;
	assign range_error    = res_q.err;

	`ASSERT_CLK(a_skid_behind_out, clk, arst_n, skid_valid_q |-> res_valid, "skid full while output empty")
	`ASSERT_NEXT(a_stall_to_skid, clk, arst_n, cmd_fire && res_valid && !res_ready, skid_valid_q, "stalled result not kept in skid")
	`ASSERT_CLK(a_load_after_item, clk, arst_n, load_pend_q |-> $past(cmd_valid && cmd_ready), "timer load without an accepted item")

endmodule

`default_nettype wire

FILE: dv/tb_sprite_frame_sequencer.sv
// Self-checking testbench for the sprite frame sequencer: frame stepping, wrap, pingpong
// bounce, repeat hold, jumps and pause control, checked against a built-in predictor.
// Depends on sfs_pkg and the sprite_frame_sequencer RTL.
`timescale 1ns / 1ps

module tb_sprite_frame_sequencer;
	import sfs_pkg::*;

	localparam int MAX_FRAMES = 256;
	localparam logic [2:0] MODE_NOP = 3'd7;
	localparam int HOLD_CYCLES = 80;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES = 9;
	localparam int PHASE_ITEMS = 10;
	localparam int IDLE_PCT = 38;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] elapsed;
		logic [7:0]  fnum;
		logic [15:0] dur;
	} cmd_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	wire         cmd_ready;
	logic [2:0]  mode = '0;
	logic [15:0] elapsed_ms = '0;
	logic [7:0]  frame_number = '0;
	logic [15:0] duration_ms = '0;
	wire         res_valid;
	logic        res_ready = 1'b0;
	wire  [7:0]  current_frame;
	wire         is_paused;
	wire         frame_advanced;
	wire         range_error;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire  [31:0] prdata;
	wire         pready;

	// Predicted sequencer state and register copies.
	logic [15:0] frame_ms [MAX_FRAMES];
	int          play_pos;
	int          ms_left;
	bit          heading_fwd;
	int          loops_left;
	bit          held_paused;
	logic [8:0]  cfg_len;
	logic [1:0]  cfg_dir;
	logic [7:0]  cfg_rep;

	res_t        expected_frames[$];
	int          errors = 0;
	bit          no_idle = 1'b0;
	int          holds_asked = 0;
	int          holds_done = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;

	sprite_frame_sequencer #(.MAX_FRAMES(MAX_FRAMES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.mode(mode),
		.elapsed_ms(elapsed_ms),
		.frame_number(frame_number),
		.duration_ms(duration_ms),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.current_frame(current_frame),
		.is_paused(is_paused),
		.frame_advanced(frame_advanced),
		.range_error(range_error),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	function automatic int active_len();
		int n;
		n = cfg_len;
		if (n < 1) n = 1;
		if (n > MAX_FRAMES) n = MAX_FRAMES;
		return n;
	endfunction

	// One frame step; a restart enters from just outside the tag.
	function automatic void step_frame_from(int from);
		int len;
		bit was_fwd;
		int idx;
		bit leaves;
		len = active_len();
		was_fwd = heading_fwd;
		idx = was_fwd ? from + 1 : from - 1;
		leaves = was_fwd ? (idx >= len) : (idx < 0);
		if (leaves) begin
			if (loops_left != 1) begin
				if (cfg_dir == DIR_PINGPONG) begin
					heading_fwd = !was_fwd;
					idx = was_fwd ? idx - 2 : idx + 2;
				end else begin
					idx = was_fwd ? 0 : len - 1;
				end
				if (loops_left > 1) loops_left--;
			end else begin
				idx = was_fwd ? len - 1 : 0;
				held_paused = 1'b1;
			end
		end
		if (idx < 0) idx = 0;
		if (idx > len - 1) idx = len - 1;
		play_pos = idx;
		ms_left = frame_ms[idx];
	endfunction

	function automatic res_t predict_frame_update(cmd_item_t c);
		int prior_pos;
		bit err;
		res_t r;
		prior_pos = play_pos;
		err = 1'b0;
		case (c.mode)
			MODE_TICK: begin
				if (!held_paused) begin
					if (int'(c.elapsed) >= ms_left) step_frame_from(play_pos);
					else ms_left -= c.elapsed;
				end
			end
			MODE_WRITE: frame_ms[c.fnum] = c.dur;
			MODE_RESTART: begin
				heading_fwd = (cfg_dir != DIR_REVERSE);
				loops_left = cfg_rep;
				step_frame_from(heading_fwd ? -1 : active_len());
			end
			MODE_PLAY: held_paused = 1'b0;
			MODE_PAUSE: held_paused = 1'b1;
			MODE_TOGGLE: held_paused = !held_paused;
			MODE_JUMP: begin
				if (int'(c.fnum) >= active_len()) begin
					err = 1'b1;
				end else begin
					play_pos = c.fnum;
					ms_left = frame_ms[c.fnum];
				end
			end
			default: ;
		endcase
		r.frame = play_pos[7:0];
		r.paused = held_paused;
		r.advanced = (play_pos != prior_pos);
		r.err = err;
		return r;
	endfunction

	function automatic cmd_item_t make_cmd(logic [2:0] m, logic [15:0] el, logic [7:0] fn,
			logic [15:0] du);
		cmd_item_t c;
		c.mode = m;
		c.elapsed = el;
		c.fnum = fn;
		c.dur = du;
		return c;
	endfunction

	// Mostly short ticks and small durations so that frames step often.
	function automatic cmd_item_t random_cmd();
		cmd_item_t c;
		int pick;
		c.mode = MODE_TICK;
		c.elapsed = 16'($urandom_range(65535));
		c.fnum = 8'($urandom_range(255));
		c.dur = 16'($urandom_range(65535));
		pick = $urandom_range(99);
		if (pick < 45) begin
			pick = $urandom_range(9);
			if (pick < 7) c.elapsed = 16'($urandom_range(12));
			else if (pick < 9) c.elapsed = 16'($urandom_range(200));
		end else if (pick < 53) begin
			c.mode = MODE_WRITE;
			if ($urandom_range(9) != 0) c.dur = 16'($urandom_range(25));
		end else if (pick < 60) begin
			c.mode = MODE_RESTART;
		end else if (pick < 72) begin
			c.mode = MODE_PLAY;
		end else if (pick < 77) begin
			c.mode = MODE_PAUSE;
		end else if (pick < 84) begin
			c.mode = MODE_TOGGLE;
		end else if (pick < 96) begin
			c.mode = MODE_JUMP;
			if ($urandom_range(4) != 0) c.fnum = 8'($urandom_range(active_len() - 1));
		end else begin
			c.mode = MODE_NOP;
		end
		return c;
	endfunction

	task automatic send_cmd(input cmd_item_t c);
		if (!no_idle)
			while ($urandom_range(99) < IDLE_PCT) begin
				cmd_valid <= 1'b0;
				@(posedge clk);
			end
		cmd_valid <= 1'b1;
		mode <= c.mode;
		elapsed_ms <= c.elapsed;
		frame_number <= c.fnum;
		duration_ms <= c.dur;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		expected_frames.insert(expected_frames.size(), predict_frame_update(c));
	endtask

	task automatic drain_results();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (expected_frames.size() != 0);
	endtask

	// psel stays high across back-to-back writes; the caller closes the access.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_TAG_LENGTH: cfg_len = value[8:0];
			REG_TAG_DIRECTION: cfg_dir = value[1:0];
			REG_REPEAT_COUNT: cfg_rep = value[7:0];
			default: ;
		endcase
	endtask

	task automatic set_tag(input int len, input logic [1:0] dir, input int rep);
		drain_results();
		write_reg(REG_TAG_LENGTH, len);
		write_reg(REG_TAG_DIRECTION, dir);
		write_reg(REG_REPEAT_COUNT, rep);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Every entry is written before any frame load can read it.
	task automatic fill_durations();
		int i;
		for (i = 0; i < MAX_FRAMES; i++)
			send_cmd(make_cmd(MODE_WRITE, 16'($urandom_range(65535)), 8'(i),
				(i % 32 == 5) ? 16'($urandom_range(65535)) : 16'($urandom_range(20))));
	endtask

	task automatic test_reset_behavior();
		send_cmd(make_cmd(MODE_TICK, 16'hFFFF, 8'h00, 16'h0000));
		send_cmd(make_cmd(MODE_NOP, 16'hFFFF, 8'hFF, 16'hFFFF));
		send_cmd(make_cmd(MODE_JUMP, 16'h0000, 8'hFF, 16'h0000));
		send_cmd(make_cmd(MODE_JUMP, 16'h0000, 8'h00, 16'h0000));
		send_cmd(make_cmd(MODE_TOGGLE, 16'h0000, 8'h00, 16'h0000));
		send_cmd(make_cmd(MODE_TOGGLE, 16'h0000, 8'h00, 16'h0000));
		send_cmd(make_cmd(MODE_PLAY, 16'h0000, 8'h00, 16'h0000));
		send_cmd(make_cmd(MODE_TICK, 16'h0000, 8'h00, 16'h0000));
		send_cmd(make_cmd(MODE_TICK, 16'hFFFF, 8'h00, 16'h0000));
		send_cmd(make_cmd(MODE_PAUSE, 16'h0000, 8'h00, 16'h0000));
		send_cmd(make_cmd(MODE_RESTART, 16'h0000, 8'h00, 16'h0000));
	endtask

	task automatic play_ticks(input int ticks);
		send_cmd(make_cmd(MODE_RESTART, 16'h0000, 8'h00, 16'h0000));
		send_cmd(make_cmd(MODE_PLAY, 16'h0000, 8'h00, 16'h0000));
		repeat (ticks) send_cmd(make_cmd(MODE_TICK, 16'hFFFF, 8'h00, 16'h0000));
	endtask

	task automatic test_playback_directions();
		// Three frames played once forward end on a held last frame.
		set_tag(3, DIR_FORWARD, 1);
		play_ticks(3);
		set_tag(3, DIR_REVERSE, 0);
		play_ticks(3);
		set_tag(3, DIR_PINGPONG, 2);
		play_ticks(3);
		set_tag(1, DIR_PINGPONG, 0);
		play_ticks(2);
		// Shrinking the tag leaves the position beyond its end.
		set_tag(8, DIR_FORWARD, 0);
		send_cmd(make_cmd(MODE_JUMP, 16'h0000, 8'd7, 16'h0000));
		set_tag(3, DIR_REVERSE, 0);
		send_cmd(make_cmd(MODE_PLAY, 16'h0000, 8'h00, 16'h0000));
		send_cmd(make_cmd(MODE_TICK, 16'hFFFF, 8'h00, 16'h0000));
	endtask

	task automatic test_random_playback();
		int p;
		int k;
		int len;
		int rep;
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: set_tag(256, DIR_FORWARD, 255);
				1: set_tag(1, DIR_PINGPONG, 0);
				2: set_tag(0, DIR_REVERSE, 1);
				3: set_tag(511, 2'd3, 2);
				default: begin
					len = ($urandom_range(3) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 12);
					rep = ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(3);
					set_tag(len, 2'($urandom_range(3)), rep);
				end
			endcase
			no_idle <= (p == 4);
			if ($urandom_range(9) < 7) begin
				send_cmd(make_cmd(MODE_RESTART, 16'($urandom_range(65535)),
					8'($urandom_range(255)), 16'h0000));
				send_cmd(make_cmd(MODE_PLAY, 16'($urandom_range(65535)),
					8'($urandom_range(255)), 16'h0000));
			end
			for (k = 0; k < PHASE_ITEMS; k++) begin
				// The sender sometimes waits for all outstanding results mid-phase.
				if (k == PHASE_ITEMS / 2 && p % 3 == 0) drain_results();
				send_cmd(random_cmd());
			end
		end
	endtask

	task automatic test_output_backpressure();
		set_tag(16, DIR_PINGPONG, 0);
		no_idle <= 1'b1;
		holds_asked <= holds_asked + 1;
		send_cmd(make_cmd(MODE_RESTART, 16'h0000, 8'h00, 16'h0000));
		send_cmd(make_cmd(MODE_PLAY, 16'h0000, 8'h00, 16'h0000));
		repeat (24) send_cmd(random_cmd());
	endtask

	// Result side: random stalls, plus long holds requested by the tests.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else if (holds_done != holds_asked) begin
			holds_done <= holds_done + 1;
			hold_left <= HOLD_CYCLES;
			res_ready <= 1'b0;
		end else if (no_idle) begin
			res_ready <= 1'b1;
		end else begin
			res_ready <= ($urandom_range(99) >= IDLE_PCT);
		end
	end

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_frames.size() == 0) begin
				$display("%0t: result with no item outstanding, expected none, actual frame %0d",
					$time, current_frame);
				errors++;
			end else begin
				want = expected_frames.pop_front();
				check_field("current_frame", want.frame, current_frame);
				check_field("is_paused", want.paused, is_paused);
				check_field("frame_advanced", want.advanced, frame_advanced);
				check_field("range_error", want.err, range_error);
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_sprite_frame_sequencer failed");
				$finish;
			end
		end
	end

	initial begin
		play_pos = 0;
		ms_left = 0;
		heading_fwd = 1'b1;
		loops_left = 0;
		held_paused = 1'b1;
		cfg_len = 9'd1;
		cfg_dir = DIR_FORWARD;
		cfg_rep = 8'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fill_durations();
		test_reset_behavior();
		test_playback_directions();
		test_random_playback();
		test_output_backpressure();
		drain_results();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("tb_sprite_frame_sequencer passed");
		else
			$display("tb_sprite_frame_sequencer failed");
		$finish;
	end

endmodule
